>>> rtl/hslp_pkg.sv
// shared types and constants for the http status line parser
// no dependencies
package hslp_pkg;

   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [1:0] KIND_MORE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  status_code;
      logic [9:0]  major;
      logic [9:0]  minor;
      logic [15:0] status_start;
      logic [15:0] line_end;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/hslp_queue.sv
// small register queue between parser front and result back end
// uses hslp_pkg for the status struct
module hslp_queue
   import hslp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output q_status_type     status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/hslp_front.sv
// parser front end: grammar state machine, digit accumulators, offsets
// uses hslp_pkg for result codes and the item record
module hslp_front
   import hslp_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_in,
   output item_type   item
);

   localparam logic [3:0] PH_START        = 4'd0;
   localparam logic [3:0] PH_H            = 4'd1;
   localparam logic [3:0] PH_HT           = 4'd2;
   localparam logic [3:0] PH_HTT          = 4'd3;
   localparam logic [3:0] PH_HTTP         = 4'd4;
   localparam logic [3:0] PH_FIRST_MAJOR  = 4'd5;
   localparam logic [3:0] PH_MAJOR        = 4'd6;
   localparam logic [3:0] PH_FIRST_MINOR  = 4'd7;
   localparam logic [3:0] PH_MINOR        = 4'd8;
   localparam logic [3:0] PH_STATUS       = 4'd9;
   localparam logic [3:0] PH_AFTER_STATUS = 4'd10;
   localparam logic [3:0] PH_TEXT         = 4'd11;
   localparam logic [3:0] PH_ALMOST       = 4'd12;

   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [13:0] VER_MAX = 14'd999;

   logic [3:0]           phase_ff, phase_in;
   logic [9:0]           major_ff, major_in;
   logic [9:0]           minor_ff, minor_in;
   logic [9:0]           code_ff, code_in;
   logic [1:0]           count_ff, count_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;

   logic                 is_digit;
   logic [3:0]           digit;
   logic [13:0]          major_mac, minor_mac;
   logic [9:0]           major_sat, minor_sat;
   logic [13:0]          code_mac;
   logic [1:0]           count_inc;
   logic [1:0]           kind;
   logic [POS_WIDTH-1:0] end_at;
   logic [POS_WIDTH+15:0] start_ext, end_ext;

   assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign digit     = byte_in[3:0];
   assign major_mac = {4'd0, major_ff} * 14'd10 + {10'd0, digit};
   assign minor_mac = {4'd0, minor_ff} * 14'd10 + {10'd0, digit};
   assign code_mac  = {4'd0, code_ff} * 14'd10 + {10'd0, digit};
   assign major_sat = (major_mac > VER_MAX) ? VER_MAX[9:0] : major_mac[9:0];
   assign minor_sat = (minor_mac > VER_MAX) ? VER_MAX[9:0] : minor_mac[9:0];
   assign count_inc = count_ff + 2'd1;

   always_comb begin
      phase_in = phase_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      code_in  = code_ff;
      count_in = count_ff;
      start_in = start_ff;
      pos_in   = pos_ff + 1'b1;
      kind     = KIND_MORE;
      end_at   = '0;
      case (phase_ff)
         PH_START: begin
            if (byte_in == CH_H) phase_in = PH_H; else kind = KIND_ERROR;
         end
         PH_H: begin
            if (byte_in == CH_T) phase_in = PH_HT; else kind = KIND_ERROR;
         end
         PH_HT: begin
            if (byte_in == CH_T) phase_in = PH_HTT; else kind = KIND_ERROR;
         end
         PH_HTT: begin
            if (byte_in == CH_P) phase_in = PH_HTTP; else kind = KIND_ERROR;
         end
         PH_HTTP: begin
            if (byte_in == CH_SLASH) phase_in = PH_FIRST_MAJOR; else kind = KIND_ERROR;
         end
         PH_FIRST_MAJOR: begin
            if (is_digit) begin
               major_in = {6'd0, digit};
               phase_in = PH_MAJOR;
            end else begin
               kind = KIND_ERROR;
            end
         end
         PH_MAJOR: begin
            if (byte_in == CH_DOT) phase_in = PH_FIRST_MINOR;
            else if (is_digit) major_in = major_sat;
            else kind = KIND_ERROR;
         end
         PH_FIRST_MINOR: begin
            if (is_digit) begin
               minor_in = {6'd0, digit};
               phase_in = PH_MINOR;
            end else begin
               kind = KIND_ERROR;
            end
         end
         PH_MINOR: begin
            if (byte_in == CH_SPACE) phase_in = PH_STATUS;
            else if (is_digit) minor_in = minor_sat;
            else kind = KIND_ERROR;
         end
         PH_STATUS: begin
            if (byte_in == CH_SPACE) begin
               phase_in = PH_STATUS;
            end else if (!is_digit) begin
               kind = KIND_ERROR;
            end else begin
               code_in  = code_mac[9:0];
               count_in = count_inc;
               if (count_inc == 2'd3) begin
                  phase_in = PH_AFTER_STATUS;
                  start_in = pos_ff - POS_WIDTH'(2);
               end
            end
         end
         PH_AFTER_STATUS: begin
            if (byte_in == CH_SPACE) phase_in = PH_TEXT;
            else if (byte_in == CH_CR) phase_in = PH_ALMOST;
            else if (byte_in == CH_LF) begin
               kind   = KIND_DONE;
               end_at = pos_ff;
            end else kind = KIND_ERROR;
         end
         PH_TEXT: begin
            if (byte_in == CH_CR) phase_in = PH_ALMOST;
            else if (byte_in == CH_LF) begin
               kind   = KIND_DONE;
               end_at = pos_ff;
            end
         end
         PH_ALMOST: begin
            if (byte_in == CH_LF) begin
               kind   = KIND_DONE;
               end_at = pos_ff - POS_WIDTH'(1);
            end else begin
               kind = KIND_ERROR;
            end
         end
         default: begin
            kind = KIND_ERROR;
         end
      endcase
      if (kind != KIND_MORE) begin
         phase_in = PH_START;
         major_in = '0;
         minor_in = '0;
         code_in  = '0;
         count_in = '0;
         pos_in   = '0;
         start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         major_ff <= '0;
         minor_ff <= '0;
         code_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         code_ff  <= code_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

   assign start_ext = {16'd0, start_ff};
   assign end_ext   = {16'd0, end_at};

   always_comb begin
      item.kind         = kind;
      item.status_code  = '0;
      item.major        = '0;
      item.minor        = '0;
      item.status_start = '0;
      item.line_end     = '0;
      if (kind == KIND_DONE) begin
         item.status_code  = code_ff;
         item.major        = major_ff;
         item.minor        = minor_ff;
         item.status_start = start_ext[15:0];
         item.line_end     = end_ext[15:0];
      end
   end

endmodule

>>> rtl/hslp_back.sv
// result back end: version multiply-add into the result output register
// uses hslp_pkg for the item record and queue status
module hslp_back
   import hslp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  item_type     item,
   input  q_status_type q_status,
   output logic         q_rd_en,
   input  logic         pop,
   output logic         empty,
   output logic [1:0]   result_kind,
   output logic [9:0]   status_code,
   output logic [19:0]  http_version,
   output logic [15:0]  status_start,
   output logic [15:0]  line_end
);

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [9:0]  code_ff;
   logic [19:0] version_ff, version_in;
   logic [15:0] start_ff;
   logic [15:0] end_ff;

   assign q_rd_en    = !q_status.empty && (!valid_ff || pop);
   assign version_in = {10'd0, item.major} * 20'd1000 + {10'd0, item.minor};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_rd_en) begin
         valid_ff <= 1'b1;
      end else if (pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd_en) begin
         kind_ff    <= item.kind;
         code_ff    <= item.status_code;
         version_ff <= version_in;
         start_ff   <= item.status_start;
         end_ff     <= item.line_end;
      end
   end

   assign empty        = !valid_ff;
   assign result_kind  = kind_ff;
   assign status_code  = code_ff;
   assign http_version = version_ff;
   assign status_start = start_ff;
   assign line_end     = end_ff;

endmodule

>>> rtl/http_status_line_parser.sv
// http status line parser top level: front end, queue, back end
// a result is queued with its byte and moves to the rsp_ output register once that is free
// throughput: one byte per cycle while req_full is low, set by the parser state update
// reset: synchronous, clears parser state and empties both the queue and the output register
// uses hslp_pkg, hslp_front, hslp_queue, hslp_back
module http_status_line_parser
   import hslp_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [9:0]  rsp_status_code,
   output logic [19:0] rsp_http_version,
   output logic [15:0] rsp_status_start,
   output logic [15:0] rsp_line_end
);

   item_type     front_item;
   item_type     back_item;
   q_status_type q_status;
   logic         accept;
   logic         q_rd_en;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   hslp_front #(
      .POS_WIDTH(POS_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .byte_in(req_byte_in),
      .item   (front_item)
   );

   hslp_queue #(
      .WIDTH($bits(item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_data(front_item),
      .rd_en  (q_rd_en),
      .rd_data(back_item),
      .status (q_status)
   );

   hslp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (back_item),
      .q_status    (q_status),
      .q_rd_en     (q_rd_en),
      .pop         (rsp_pop),
      .empty       (rsp_empty),
      .result_kind (rsp_result_kind),
      .status_code (rsp_status_code),
      .http_version(rsp_http_version),
      .status_start(rsp_status_start),
      .line_end    (rsp_line_end)
   );

endmodule

>>> rtl/hslp_checker.sv
// port-level assertions for the http status line parser, bound to the top level
// uses hslp_pkg for result codes
module hslp_checker
   import hslp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [7:0]  req_byte_in,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_result_kind,
   input logic [9:0]  rsp_status_code,
   input logic [19:0] rsp_http_version,
   input logic [15:0] rsp_status_start,
   input logic [15:0] rsp_line_end
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results pending after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_result_kind == KIND_MORE || rsp_result_kind == KIND_DONE ||
                      rsp_result_kind == KIND_ERROR))
      else $error("illegal result kind");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_DONE) |->
      (rsp_status_code == '0 && rsp_http_version == '0 &&
       rsp_status_start == '0 && rsp_line_end == '0))
      else $error("non-zero fields on a transaction that is not done");

   a_done_ranges: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_DONE) |->
      (rsp_status_code <= 10'd999 && rsp_http_version <= 20'd999999))
      else $error("done transaction out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_result_kind) && $stable(rsp_status_code) &&
       $stable(rsp_http_version) && $stable(rsp_line_end)))
      else $error("stalled transaction changed");

endmodule

bind http_status_line_parser hslp_checker u_hslp_checker (.*);
